[rtl/bdsd_pkg.sv]
// Shared types and constants for the binaural delay-and-sum downmixer.
// No dependencies; imported by the multiplier, the rings and the top level.
package bdsd_pkg;

  localparam int DEF_OPS         = 20;
  localparam int DEF_DELAY_DEPTH = 4096;

  localparam int SMP_W  = 24;
  localparam int GAIN_W = 16;
  localparam int ACC_W  = 40;
  localparam int RND_W  = ACC_W - 12;
  localparam int DLY_W  = 12;

  localparam logic CMD_TABLE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam logic REG_ACTIVE_OPS = 1'b0;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_FETCH,
    S_CHECK,
    S_MUL,
    S_ADD,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic we_l;
    logic we_r;
    logic re;
  } ring_ctl_t;

endpackage

[rtl/bdsd_mul.sv]
// Digit-serial signed multiplier: gain taken four bits per cycle, then rounded by 2^-12.
// Depends on bdsd_pkg.
module bdsd_mul (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [bdsd_pkg::SMP_W-1:0]  sample,
  input  logic signed [bdsd_pkg::GAIN_W-1:0] gain,
  output logic                              done,
  output logic signed [bdsd_pkg::RND_W-1:0]  rnd
);
  import bdsd_pkg::*;

  logic                    busy;
  logic                    fin;
  logic [1:0]              cnt;
  logic [GAIN_W-1:0]       gsr;
  logic signed [SMP_W-1:0] smp;
  logic signed [ACC_W-1:0] acc;

  logic signed [4:0]       dig;
  logic signed [SMP_W+4:0] pp;
  logic signed [ACC_W-1:0] pp_sh;
  logic signed [ACC_W:0]   rsum;

  // The top digit carries the sign of the gain; the lower digits are unsigned.
  always_comb begin
    dig   = $signed({(cnt == 2'd3) ? gsr[3] : 1'b0, gsr[3:0]});
    pp    = smp * dig;
    pp_sh = ACC_W'(pp) <<< {cnt, 2'b00};
    rsum  = (ACC_W+1)'(acc) + (ACC_W+1)'(2048);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        fin  <= 1'b0;
      end else if (busy) begin
        if (cnt == 2'd3) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        fin  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt <= 2'd0;
      gsr <= gain;
      smp <= sample;
      acc <= '0;
    end else if (busy) begin
      acc <= acc + pp_sh;
      gsr <= gsr >> 4;
      cnt <= cnt + 2'd1;
    end else if (fin) begin
      rnd <= rsum[ACC_W-1:12];
    end
  end

endmodule

[rtl/bdsd_ring.sv]
// Left and right accumulator rings, one write and one registered read per cycle.
// Depends on bdsd_pkg.
module bdsd_ring #(
  parameter int DELAY_DEPTH = bdsd_pkg::DEF_DELAY_DEPTH,
  parameter int AW          = $clog2(DELAY_DEPTH)
) (
  input  logic                      clk,
  input  bdsd_pkg::ring_ctl_t       ctl,
  input  logic [AW-1:0]             waddr,
  input  logic [bdsd_pkg::ACC_W-1:0] wdata,
  input  logic [AW-1:0]             raddr,
  output logic [bdsd_pkg::ACC_W-1:0] rdata_l,
  output logic [bdsd_pkg::ACC_W-1:0] rdata_r
);
  import bdsd_pkg::*;

  logic [ACC_W-1:0] mem_l [DELAY_DEPTH];
  logic [ACC_W-1:0] mem_r [DELAY_DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.we_l) begin
      mem_l[waddr] <= wdata;
    end
    if (ctl.we_r) begin
      mem_r[waddr] <= wdata;
    end
    if (ctl.re) begin
      rdata_l <= mem_l[raddr];
      rdata_r <= mem_r[raddr];
    end
  end

endmodule

[rtl/binaural_delay_sum_downmix.sv]
// Top level of the binaural delay-and-sum downmixer: sequencer, operation table,
// configuration port. Depends on bdsd_pkg, bdsd_mul and bdsd_ring.
//
// Usage. Items arrive on the s_ stream. tuser is the command: 0 loads an
// operation table entry (index, source channel, ear, delay, gain), 1 delivers
// one channel sample; tlast marks the last sample of a frame. Each sample is
// multiplied by the gain of every active entry whose source matches its
// channel and added into the left or right ring at ring position plus delay.
// At frame end the current stereo slot leaves on the m_ stream, saturated to
// 24 bits, and the slot is cleared. active_ops is written through the APB port.
//
// Throughput: one item at a time. A table load reduces the delay modulo the
// ring depth, one quotient bit per cycle. A sample scans the active entries:
// each one is fetched and its source checked, and a matching entry also runs
// the four gain digits of the serial multiplier, rounding, and the ring
// update; the scan then ends, and a frame end adds the output step.
// Reset: all control state clears and the rings are swept to zero, one slot
// per cycle, during which s_tready stays low.
// A result waits in the output register while m_tready is low; the next item
// is still taken, and only a following frame end waits for that register.
module binaural_delay_sum_downmix #(
  parameter int OPS         = bdsd_pkg::DEF_OPS,
  parameter int DELAY_DEPTH = bdsd_pkg::DEF_DELAY_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // op_index[4:0], op_source[8:5], op_ear[9], op_delay[21:10], op_gain[37:22],
  // sample[61:38], channel[65:62], zero fill [71:66]
  input  logic [71:0] s_tdata,
  // cmd[0]
  input  logic        s_tuser,
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  // left_out[23:0], right_out[47:24]
  output logic [47:0] m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bdsd_pkg::*;

  localparam int AW  = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
  localparam int TW  = $clog2(OPS);
  localparam int IW  = $clog2(OPS + 1);
  localparam int MW  = AW + DLY_W + 1;

  state_t state, state_next;

  // Configuration register.
  logic [4:0] active_ops;
  logic [IW-1:0] n_eff;

  // Operation table; entries are undefined until loaded.
  logic [3:0]         tbl_src  [OPS];
  logic               tbl_ear  [OPS];
  logic [AW-1:0]      tbl_dly  [OPS];
  logic [GAIN_W-1:0]  tbl_gain [OPS];

  logic [3:0]         t_src;
  logic               t_ear;
  logic [AW-1:0]      t_dly;
  logic [GAIN_W-1:0]  t_gain;

  // Latched item fields.
  logic [4:0]          idx_q;
  logic [3:0]          src_q;
  logic                ear_q;
  logic [DLY_W-1:0]    dly_r;
  logic [GAIN_W-1:0]   gain_q;
  logic [SMP_W-1:0]    smp_q;
  logic [3:0]          chan_q;
  logic                fend_q;
  logic [3:0]          k;

  logic [AW-1:0]       pos;
  logic [AW-1:0]       clr;
  logic [AW-1:0]       slot;
  logic [IW-1:0]       i;

  logic [AW:0]         slot_sum;
  logic [AW-1:0]       slot_calc;
  logic [MW-1:0]       den;
  logic                sub_ok;
  logic [DLY_W-1:0]    dly_next;

  ring_ctl_t           rctl;
  logic [AW-1:0]       waddr, raddr;
  logic [ACC_W-1:0]    wdata;
  logic [ACC_W-1:0]    rdata_l, rdata_r;

  logic                mul_start, mul_done;
  logic signed [RND_W-1:0] rnd;

  logic signed [ACC_W-1:0] rv;
  logic signed [ACC_W:0]   asum;
  logic [ACC_W-1:0]        asat;
  logic                    out_free;
  logic                    accept;

  function automatic logic [SMP_W-1:0] sat_out(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'(signed'(24'sh7FFFFF));
    lo = ACC_W'(signed'(24'sh800000));
    if (v > hi) begin
      return 24'h7FFFFF;
    end else if (v < lo) begin
      return 24'h800000;
    end
    return v[SMP_W-1:0];
  endfunction

  assign pready   = 1'b1;
  assign prdata   = {27'd0, active_ops};
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    if (7'(active_ops) > 7'(OPS)) begin
      n_eff = IW'(OPS);
    end else begin
      n_eff = IW'(active_ops);
    end
  end

  // Ring slot for the fetched entry: position plus reduced delay, one wrap at most.
  always_comb begin
    slot_sum = (AW+1)'(pos) + (AW+1)'(t_dly);
    if (slot_sum >= (AW+1)'(DELAY_DEPTH)) begin
      slot_calc = AW'(slot_sum - (AW+1)'(DELAY_DEPTH));
    end else begin
      slot_calc = AW'(slot_sum);
    end
  end

  // One restoring step of delay modulo depth per cycle, quotient bit k.
  always_comb begin
    den      = MW'(DELAY_DEPTH) << k;
    sub_ok   = MW'(dly_r) >= den;
    dly_next = sub_ok ? (dly_r - den[DLY_W-1:0]) : dly_r;
  end

  // Ring update with saturation to the 40-bit accumulator range.
  always_comb begin
    rv   = t_ear ? signed'(rdata_r) : signed'(rdata_l);
    asum = (ACC_W+1)'(rv) + (ACC_W+1)'(rnd);
    if (asum[ACC_W] != asum[ACC_W-1]) begin
      asat = asum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      asat = asum[ACC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    rctl       = '0;
    waddr      = slot;
    raddr      = pos;
    wdata      = '0;
    mul_start  = 1'b0;
    unique case (state)
      S_CLEAR: begin
        rctl.we_l = 1'b1;
        rctl.we_r = 1'b1;
        waddr     = clr;
        if (clr == AW'(DELAY_DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = (s_tuser == CMD_TABLE) ? S_MOD : S_FETCH;
        end
      end
      S_MOD: begin
        if (k == 4'd0) begin
          state_next = S_IDLE;
        end
      end
      S_FETCH: begin
        if (i == n_eff) begin
          if (fend_q) begin
            rctl.re    = 1'b1;
            raddr      = pos;
            state_next = S_EMIT;
          end else begin
            state_next = S_IDLE;
          end
        end else begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (t_src == chan_q) begin
          rctl.re    = 1'b1;
          raddr      = slot_calc;
          mul_start  = 1'b1;
          state_next = S_MUL;
        end else begin
          state_next = S_FETCH;
        end
      end
      S_MUL: begin
        if (mul_done) begin
          state_next = S_ADD;
        end
      end
      S_ADD: begin
        rctl.we_l  = !t_ear;
        rctl.we_r  = t_ear;
        waddr      = slot;
        wdata      = asat;
        state_next = S_FETCH;
      end
      S_EMIT: begin
        if (out_free) begin
          rctl.we_l  = 1'b1;
          rctl.we_r  = 1'b1;
          waddr      = pos;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      active_ops <= '0;
      pos        <= '0;
      clr        <= '0;
      i          <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (psel && penable && pwrite && (paddr[2] == REG_ACTIVE_OPS)) begin
        active_ops <= pwdata[4:0];
      end
      if (state == S_CLEAR) begin
        clr <= clr + AW'(1);
      end
      if (accept) begin
        i <= '0;
      end else if ((state == S_ADD) || ((state == S_CHECK) && (t_src != chan_q))) begin
        i <= i + IW'(1);
      end
      if ((state == S_EMIT) && out_free) begin
        m_tvalid <= 1'b1;
        pos      <= (pos == AW'(DELAY_DEPTH - 1)) ? '0 : pos + AW'(1);
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers and table.
  always_ff @(posedge clk) begin
    if (accept) begin
      idx_q  <= s_tdata[4:0];
      src_q  <= s_tdata[8:5];
      ear_q  <= s_tdata[9];
      dly_r  <= s_tdata[21:10];
      gain_q <= s_tdata[37:22];
      smp_q  <= s_tdata[61:38];
      chan_q <= s_tdata[65:62];
      fend_q <= s_tlast;
      k      <= 4'(DLY_W - 1);
    end
    if (state == S_MOD) begin
      dly_r <= dly_next;
      k     <= k - 4'd1;
      if ((k == 4'd0) && (7'(idx_q) < 7'(OPS))) begin
        tbl_src[TW'(idx_q)]  <= src_q;
        tbl_ear[TW'(idx_q)]  <= ear_q;
        tbl_dly[TW'(idx_q)]  <= AW'(dly_next);
        tbl_gain[TW'(idx_q)] <= gain_q;
      end
    end
    if ((state == S_FETCH) && (i != n_eff)) begin
      t_src  <= tbl_src[TW'(i)];
      t_ear  <= tbl_ear[TW'(i)];
      t_dly  <= tbl_dly[TW'(i)];
      t_gain <= tbl_gain[TW'(i)];
    end
    if (state == S_CHECK) begin
      slot <= slot_calc;
    end
    if ((state == S_EMIT) && out_free) begin
      m_tdata <= {sat_out(signed'(rdata_r)), sat_out(signed'(rdata_l))};
    end
  end

  bdsd_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .sample (signed'(smp_q)),
    .gain   (signed'(t_gain)),
    .done   (mul_done),
    .rnd    (rnd)
  );

  bdsd_ring #(
    .DELAY_DEPTH (DELAY_DEPTH),
    .AW          (AW)
  ) u_ring (
    .clk     (clk),
    .ctl     (rctl),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr   (raddr),
    .rdata_l (rdata_l),
    .rdata_r (rdata_r)
  );

endmodule

[rtl/bdsd_check.sv]
// Port-level checker for the downmixer, bound to the top level below.
// Depends only on the top level's ports.
module bdsd_check (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result pending after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> rst || (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

  a_table_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !s_tuser |=> !s_tready)
    else $error("table load did not occupy the block");

  a_cfg_readback: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && !paddr[2] |=>
      rst || ((prdata[4:0] == $past(pwdata[4:0])) && (prdata[31:5] == 27'd0)))
    else $error("active_ops readback mismatch");

endmodule

bind binaural_delay_sum_downmix bdsd_check u_check (.*);
